### hw/rtl/rcf_pkg.sv
package rcf_pkg;

    // Fixed widths of the item and result fields
    localparam int HANDLE_PORT_W = 16;
    localparam int BYTE_W        = 8;
    localparam int SLOT_IDX_OUT_W = 4;
    localparam int LEN_OUT_W     = 8;
    localparam int COUNT_W       = 32;

    // Read and write strobes of one memory port
    typedef struct packed {
        logic rd;
        logic wr;
    } rcf_mem_cmd_t;

    // One result beat as held on the output ports
    typedef struct packed {
        logic                      changed;
        logic                      no_slot;
        logic [SLOT_IDX_OUT_W-1:0] slot_index;
        logic                      new_slot;
        logic [LEN_OUT_W-1:0]      stored_length;
        logic [COUNT_W-1:0]        notification_total;
        logic [COUNT_W-1:0]        duplicate_total;
    } rcf_result_t;

endpackage

### hw/rtl/rcf_ram.sv
module rcf_ram
    import rcf_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  rcf_mem_cmd_t      cmd,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write one entry, register the read data
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/report_change_filter.sv
// Per-handle duplicate-report filter.
// Input channel: a beat (report_handle, data_byte, has_byte, last_byte) is taken
// at a rising edge where start is high and busy is low. One beat carries at most
// one byte of a report; last_byte closes the report. The handle counts only on
// the first beat of a report.
// Result channel: the closing beat yields one result, shown for exactly one
// cycle with done high; the receiver takes it at the end of that cycle and
// cannot stall it. done rises in the cycle busy falls after that beat.
// Sequencing: a beat inside a report reads its snapshot byte as it is taken,
// then compares and writes it back in the byte memory. The first beat of a
// report also walks the slot table one entry at a time (read, then compare),
// up to the matching slot or, when no slot matches, through all slots in use;
// busy stays high until the beat is done, so no new beat is taken before then.
// Reset: all slots free, counters zero, no report open. The memories are not
// cleared; slots are claimed in order, so a fill count marks the used ones.
module report_change_filter
    import rcf_pkg::*;
#(
    parameter int SLOT_COUNT     = 16,
    parameter int SNAPSHOT_BYTES = 128,
    parameter int HANDLE_BITS    = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [HANDLE_PORT_W-1:0]  report_handle,
    input  logic [BYTE_W-1:0]         data_byte,
    input  logic                      has_byte,
    input  logic                      last_byte,
    output logic                      busy,
    output logic                      done,
    output logic                      changed,
    output logic                      no_slot,
    output logic [SLOT_IDX_OUT_W-1:0] slot_index,
    output logic                      new_slot,
    output logic [LEN_OUT_W-1:0]      stored_length,
    output logic [COUNT_W-1:0]        notification_total,
    output logic [COUNT_W-1:0]        duplicate_total
);

    localparam int HW      = (HANDLE_BITS < HANDLE_PORT_W) ? HANDLE_BITS : HANDLE_PORT_W;
    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FILL_W  = $clog2(SLOT_COUNT + 1);
    localparam int POS_W   = $clog2(SNAPSHOT_BYTES + 1);
    localparam int BDEPTH  = SLOT_COUNT * SNAPSHOT_BYTES;
    localparam int BADDR_W = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int META_W  = HW + POS_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_MATCH = 3'd2;
    localparam logic [2:0] ST_ACC   = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;

    logic [2:0]         state_reg,      state_next;
    logic               in_report_reg,  in_report_next;
    logic [HW-1:0]      handle_reg,     handle_next;
    logic [BYTE_W-1:0]  data_reg,       data_next;
    logic               has_reg,        has_next;
    logic               last_reg,       last_next;
    logic [SLOT_W-1:0]  active_reg,     active_next;
    logic [BADDR_W-1:0] base_reg,       base_next;
    logic               untracked_reg,  untracked_next;
    logic               fresh_reg,      fresh_next;
    logic [POS_W-1:0]   pos_reg,        pos_next;
    logic               mismatch_reg,   mismatch_next;
    logic [FILL_W-1:0]  fill_reg,       fill_next;
    logic [FILL_W-1:0]  scan_reg,       scan_next;
    logic [COUNT_W-1:0] notify_reg,     notify_next;
    logic [COUNT_W-1:0] dup_reg,        dup_next;
    logic               done_reg,       done_next;
    rcf_result_t        res_reg,        res_next;

    rcf_mem_cmd_t       meta_cmd;
    logic [SLOT_W-1:0]  meta_addr;
    logic [META_W-1:0]  meta_wdata;
    logic [META_W-1:0]  meta_rdata;
    rcf_mem_cmd_t       byte_cmd;
    logic [BADDR_W-1:0] byte_addr;
    logic [BYTE_W-1:0]  byte_rdata;

    logic               accept;
    logic               enter_upd;
    logic               scan_end;
    logic               pos_below;
    logic               byte_hit;
    logic               byte_wr;
    logic               byte_diff;
    logic [POS_W-1:0]   pos_upd;
    logic               report_changed;
    logic [HW-1:0]      meta_handle;
    logic [POS_W-1:0]   meta_len;

    assign accept      = start && (state_reg == ST_IDLE);
    assign enter_upd   = (accept && in_report_reg) || (state_reg == ST_ACC);
    assign scan_end    = (scan_reg == fill_reg);
    assign pos_below   = (pos_reg < POS_W'(SNAPSHOT_BYTES));
    assign byte_hit    = has_reg && pos_below;
    assign byte_wr     = (state_reg == ST_UPD) && byte_hit && !untracked_reg;
    assign meta_handle = meta_rdata[POS_W +: HW];
    assign meta_len    = meta_rdata[POS_W-1:0];
    assign byte_diff   = byte_wr && (byte_rdata != data_reg);
    assign pos_upd     = pos_reg + POS_W'(byte_hit);
    assign report_changed = untracked_reg || mismatch_reg || byte_diff || (meta_len != pos_upd);

    // Slot table: handle and stored length of each claimed slot
    always_comb
    begin
        meta_cmd.rd = enter_upd || ((state_reg == ST_SCAN) && !scan_end);
        meta_cmd.wr = 1'b0;
        meta_addr   = active_reg;
        meta_wdata  = {meta_handle, pos_upd};
        if (state_reg == ST_SCAN)
        begin
            meta_addr  = scan_reg[SLOT_W-1:0];
            meta_wdata = {handle_reg, {POS_W{1'b0}}};
            meta_cmd.wr = scan_end && (fill_reg < FILL_W'(SLOT_COUNT));
        end
        else if (state_reg == ST_UPD)
        begin
            meta_cmd.wr = last_reg && report_changed && !untracked_reg;
        end
    end

    // Snapshot bytes: read on the way into the update cycle, write back in it
    assign byte_addr   = base_reg + BADDR_W'(pos_reg);
    assign byte_cmd.rd = enter_upd && pos_below && !untracked_reg;
    assign byte_cmd.wr = byte_wr;

    rcf_ram #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (SLOT_W),
        .DATA_W (META_W)
    ) u_slot_table (
        .clk     (clk),
        .cmd     (meta_cmd),
        .addr    (meta_addr),
        .wr_data (meta_wdata),
        .rd_data (meta_rdata)
    );

    rcf_ram #(
        .DEPTH  (BDEPTH),
        .ADDR_W (BADDR_W),
        .DATA_W (BYTE_W)
    ) u_snapshot (
        .clk     (clk),
        .cmd     (byte_cmd),
        .addr    (byte_addr),
        .wr_data (data_reg),
        .rd_data (byte_rdata)
    );

    // Sequence one beat: slot lookup on a report's first beat, then byte update
    always_comb
    begin
        state_next     = state_reg;
        in_report_next = in_report_reg;
        handle_next    = handle_reg;
        data_next      = data_reg;
        has_next       = has_reg;
        last_next      = last_reg;
        active_next    = active_reg;
        base_next      = base_reg;
        untracked_next = untracked_reg;
        fresh_next     = fresh_reg;
        pos_next       = pos_reg;
        mismatch_next  = mismatch_reg;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        notify_next    = notify_reg;
        dup_next       = dup_reg;
        done_next      = 1'b0;
        res_next       = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    handle_next = report_handle[HW-1:0];
                    data_next   = data_byte;
                    has_next    = has_byte;
                    last_next   = last_byte;
                    if (in_report_reg)
                    begin
                        state_next = ST_UPD;
                    end
                    else
                    begin
                        in_report_next = 1'b1;
                        pos_next       = '0;
                        mismatch_next  = 1'b0;
                        scan_next      = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    // no match among used slots: claim the next one or go untracked
                    if (fill_reg < FILL_W'(SLOT_COUNT))
                    begin
                        active_next    = fill_reg[SLOT_W-1:0];
                        base_next      = BADDR_W'(fill_reg[SLOT_W-1:0]) *
                                         BADDR_W'(SNAPSHOT_BYTES);
                        untracked_next = 1'b0;
                        fresh_next     = 1'b1;
                        fill_next      = fill_reg + FILL_W'(1);
                    end
                    else
                    begin
                        active_next    = '0;
                        base_next      = '0;
                        untracked_next = 1'b1;
                        fresh_next     = 1'b0;
                    end
                    state_next = ST_ACC;
                end
                else
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                if (meta_handle == handle_reg)
                begin
                    active_next    = scan_reg[SLOT_W-1:0];
                    base_next      = BADDR_W'(scan_reg[SLOT_W-1:0]) *
                                     BADDR_W'(SNAPSHOT_BYTES);
                    untracked_next = 1'b0;
                    fresh_next     = 1'b0;
                    state_next     = ST_ACC;
                end
                else
                begin
                    scan_next  = scan_reg + FILL_W'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_ACC:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                pos_next      = pos_upd;
                mismatch_next = mismatch_reg || byte_diff;
                state_next    = ST_IDLE;
                if (last_reg)
                begin
                    in_report_next = 1'b0;
                    notify_next    = notify_reg + COUNT_W'(1);
                    dup_next       = dup_reg + COUNT_W'(!report_changed);
                    done_next      = 1'b1;
                    res_next.changed       = report_changed;
                    res_next.no_slot       = untracked_reg;
                    res_next.slot_index    = untracked_reg ? '0 :
                                             SLOT_IDX_OUT_W'(active_reg);
                    res_next.new_slot      = fresh_reg && !untracked_reg;
                    res_next.stored_length = LEN_OUT_W'(pos_upd);
                    res_next.notification_total = notify_reg + COUNT_W'(1);
                    res_next.duplicate_total    = dup_reg + COUNT_W'(!report_changed);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_report_reg <= 1'b0;
            active_reg    <= '0;
            base_reg      <= '0;
            untracked_reg <= 1'b0;
            fresh_reg     <= 1'b0;
            pos_reg       <= '0;
            mismatch_reg  <= 1'b0;
            fill_reg      <= '0;
            scan_reg      <= '0;
            notify_reg    <= '0;
            dup_reg       <= '0;
            done_reg      <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            in_report_reg <= in_report_next;
            active_reg    <= active_next;
            base_reg      <= base_next;
            untracked_reg <= untracked_next;
            fresh_reg     <= fresh_next;
            pos_reg       <= pos_next;
            mismatch_reg  <= mismatch_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            notify_reg    <= notify_next;
            dup_reg       <= dup_next;
            done_reg      <= done_next;
            res_reg       <= res_next;
        end
    end

    // Beat fields
    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
        data_reg   <= data_next;
        has_reg    <= has_next;
        last_reg   <= last_next;
    end

    assign busy               = (state_reg != ST_IDLE);
    assign done               = done_reg;
    assign changed            = res_reg.changed;
    assign no_slot            = res_reg.no_slot;
    assign slot_index         = res_reg.slot_index;
    assign new_slot           = res_reg.new_slot;
    assign stored_length      = res_reg.stored_length;
    assign notification_total = res_reg.notification_total;
    assign duplicate_total    = res_reg.duplicate_total;

endmodule

### hw/rtl/rcf_checker.sv
module rcf_checker
    import rcf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      busy,
    input  logic                      done,
    input  logic                      changed,
    input  logic                      no_slot,
    input  logic [SLOT_IDX_OUT_W-1:0] slot_index,
    input  logic                      new_slot,
    input  logic [COUNT_W-1:0]        notification_total,
    input  logic [COUNT_W-1:0]        duplicate_total
);

    // A result beat follows work on a closing beat and leaves the block idle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result beat without a beat in progress");

    // No two result beats in a row
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beats back to back");

    // An untracked report is changed, in no slot, and claims nothing
    a_no_slot_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_slot) |-> (changed && (slot_index == '0) && !new_slot))
        else $error("untracked report with inconsistent fields");

    // The duplicate total moves exactly on an unchanged report
    a_dup_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (changed == $stable(duplicate_total)))
        else $error("duplicate total out of step with changed");

    // The report total holds between result beats
    a_notify_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable(notification_total))
        else $error("report total moved without a result beat");

endmodule

bind report_change_filter rcf_checker u_rcf_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .busy               (busy),
    .done               (done),
    .changed            (changed),
    .no_slot            (no_slot),
    .slot_index         (slot_index),
    .new_slot           (new_slot),
    .notification_total (notification_total),
    .duplicate_total    (duplicate_total)
);
